### design/rbst_pkg.sv
// constants, register codes and the slab saturation function for ray_box_slab_test
// no dependencies
package rbst_pkg;

  localparam int FRAC_BITS = 16;
  localparam int Q_W       = 32;
  localparam int D_W       = Q_W + 1;
  localparam int P_W       = D_W + Q_W;
  localparam int AXES      = 3;
  localparam int ADDR_W    = 5;
  localparam int IDX_W     = 3;

  localparam logic [IDX_W-1:0] REG_LOWER_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_LOWER_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_LOWER_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_UPPER_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_UPPER_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_UPPER_Z = 3'd5;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  localparam logic signed [P_W-1:0] SAT_HI = {{(P_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic signed [P_W-1:0] SAT_LO = {{(P_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};

  // floor shift of the exact product, then clamp to the q range
  function automatic logic signed [Q_W-1:0] slab_sat(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] sh;
    logic signed [Q_W-1:0] r;
    sh = p >>> FRAC_BITS;
    if (sh > SAT_HI) begin
      r = Q_MAX;
    end else if (sh < SAT_LO) begin
      r = Q_MIN;
    end else begin
      r = sh[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

### design/ray_box_slab_test.sv
// ray versus axis-aligned box slab test, five register stages
// depends on rbst_pkg
//
//  port group       | direction | beat
//  start/busy + ray | in        | start_i high while busy_o low (busy_o is always low)
//  done + result    | out       | done_o high for one cycle, taken at the edge ending it
//  apb config       | in/out    | psel & penable & pwrite at the access edge
//
// one ray is taken every cycle; the result is registered through stages s1 to s4 and
// the output register before it is on the ports
// stages: box minus origin, multiply with floor shift and clamp, per-axis min/max,
// entry/exit reduction, hit compare
// reset sets the box empty (lower at max, upper at min) and clears all stage valids
// the receiver cannot stall, so nothing ever holds the pipeline
module ray_box_slab_test
  import rbst_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [Q_W-1:0]    origin_x_i,
  input  logic signed [Q_W-1:0]    origin_y_i,
  input  logic signed [Q_W-1:0]    origin_z_i,
  input  logic signed [Q_W-1:0]    inv_dir_x_i,
  input  logic signed [Q_W-1:0]    inv_dir_y_i,
  input  logic signed [Q_W-1:0]    inv_dir_z_i,
  input  logic signed [Q_W-1:0]    max_distance_i,
  output logic                     done_o,
  output logic                     hit_o,
  output logic signed [Q_W-1:0]    entry_distance_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [Q_W-1:0]           pwdata,
  output logic [Q_W-1:0]           prdata,
  output logic                     pready
);

  logic signed [Q_W-1:0] lower_q [AXES];
  logic signed [Q_W-1:0] upper_q [AXES];
  logic [IDX_W-1:0]      reg_idx;
  logic                  cfg_wr;

  logic signed [Q_W-1:0] org [AXES];
  logic signed [Q_W-1:0] inv [AXES];

  logic                  s1_vld_q;
  logic signed [D_W-1:0] s1_dlo_q [AXES];
  logic signed [D_W-1:0] s1_dhi_q [AXES];
  logic signed [Q_W-1:0] s1_inv_q [AXES];
  logic signed [Q_W-1:0] s1_lim_q;

  logic                  s2_vld_q;
  logic signed [P_W-1:0] s2_plo [AXES];
  logic signed [P_W-1:0] s2_phi [AXES];
  logic signed [Q_W-1:0] s2_tlo_d [AXES];
  logic signed [Q_W-1:0] s2_thi_d [AXES];
  logic signed [Q_W-1:0] s2_tlo_q [AXES];
  logic signed [Q_W-1:0] s2_thi_q [AXES];
  logic signed [Q_W-1:0] s2_lim_q;

  logic                  s3_vld_q;
  logic signed [Q_W-1:0] s3_mn_d [AXES];
  logic signed [Q_W-1:0] s3_mx_d [AXES];
  logic signed [Q_W-1:0] s3_mn_q [AXES];
  logic signed [Q_W-1:0] s3_mx_q [AXES];
  logic signed [Q_W-1:0] s3_lim_q;

  logic                  s4_vld_q;
  logic signed [Q_W-1:0] ent01, ext01, s4_entry_d, s4_exit_d;
  logic signed [Q_W-1:0] s4_entry_q, s4_exit_q, s4_lim_q;

  logic                  hit_d;
  logic                  done_q, hit_q;
  logic signed [Q_W-1:0] dist_q;

  assign busy_o = 1'b0;
  assign pready = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      REG_LOWER_X: prdata = lower_q[0];
      REG_LOWER_Y: prdata = lower_q[1];
      REG_LOWER_Z: prdata = lower_q[2];
      REG_UPPER_X: prdata = upper_q[0];
      REG_UPPER_Y: prdata = upper_q[1];
      REG_UPPER_Z: prdata = upper_q[2];
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        lower_q[a] <= Q_MAX;
        upper_q[a] <= Q_MIN;
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LOWER_X: lower_q[0] <= pwdata;
        REG_LOWER_Y: lower_q[1] <= pwdata;
        REG_LOWER_Z: lower_q[2] <= pwdata;
        REG_UPPER_X: upper_q[0] <= pwdata;
        REG_UPPER_Y: upper_q[1] <= pwdata;
        REG_UPPER_Z: upper_q[2] <= pwdata;
        default: ;
      endcase
    end
  end

  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign inv[0] = inv_dir_x_i;
  assign inv[1] = inv_dir_y_i;
  assign inv[2] = inv_dir_z_i;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      s2_plo[a]   = P_W'(s1_dlo_q[a]) * P_W'(s1_inv_q[a]);
      s2_phi[a]   = P_W'(s1_dhi_q[a]) * P_W'(s1_inv_q[a]);
      s2_tlo_d[a] = slab_sat(s2_plo[a]);
      s2_thi_d[a] = slab_sat(s2_phi[a]);
      s3_mn_d[a]  = (s2_tlo_q[a] < s2_thi_q[a]) ? s2_tlo_q[a] : s2_thi_q[a];
      s3_mx_d[a]  = (s2_tlo_q[a] < s2_thi_q[a]) ? s2_thi_q[a] : s2_tlo_q[a];
    end
    ent01      = (s3_mn_q[1] > s3_mn_q[0]) ? s3_mn_q[1] : s3_mn_q[0];
    s4_entry_d = (s3_mn_q[2] > ent01) ? s3_mn_q[2] : ent01;
    ext01      = (s3_mx_q[1] < s3_mx_q[0]) ? s3_mx_q[1] : s3_mx_q[0];
    s4_exit_d  = (s3_mx_q[2] < ext01) ? s3_mx_q[2] : ext01;
    hit_d = !s4_exit_q[Q_W-1] && (s4_entry_q <= s4_exit_q) && (s4_entry_q < s4_lim_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= start_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      done_q   <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < AXES; a++) begin
      s1_dlo_q[a] <= {lower_q[a][Q_W-1], lower_q[a]} - {org[a][Q_W-1], org[a]};
      s1_dhi_q[a] <= {upper_q[a][Q_W-1], upper_q[a]} - {org[a][Q_W-1], org[a]};
      s1_inv_q[a] <= inv[a];
      s2_tlo_q[a] <= s2_tlo_d[a];
      s2_thi_q[a] <= s2_thi_d[a];
      s3_mn_q[a]  <= s3_mn_d[a];
      s3_mx_q[a]  <= s3_mx_d[a];
    end
    s1_lim_q   <= max_distance_i;
    s2_lim_q   <= s1_lim_q;
    s3_lim_q   <= s2_lim_q;
    s4_lim_q   <= s3_lim_q;
    s4_entry_q <= s4_entry_d;
    s4_exit_q  <= s4_exit_d;
    hit_q      <= hit_d;
    dist_q     <= hit_d ? s4_entry_q : '0;
  end

  assign done_o           = done_q;
  assign hit_o            = hit_q;
  assign entry_distance_o = dist_q;

endmodule
